FILE: hdl/case_insensitive_substring_search_defines.svh
// Assertion macros for the case-insensitive substring search block.
// No dependencies; included by the top level only.
`ifndef CASE_INSENSITIVE_SUBSTRING_SEARCH_DEFINES_SVH
`define CASE_INSENSITIVE_SUBSTRING_SEARCH_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CISS_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ciss: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CISS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ciss: next-cycle check failed");

`endif

FILE: hdl/ciss_pkg.sv
// Shared constants, types and helpers for the case-insensitive substring search.
// No dependencies; imported by every module of the block.
`default_nettype none

package ciss_pkg;

  localparam int unsigned MAX_PATTERN   = 32;
  localparam int unsigned MAX_REGION    = 65536;

  localparam int unsigned CFG_DATA_W    = 64;
  localparam int unsigned CFG_IDX_W     = 3;
  localparam int unsigned LEN_W         = 6;
  localparam int unsigned POS_W         = 16;
  localparam int unsigned BYTE_W        = 8;

  // Pattern bytes held in the four pattern registers.
  localparam int unsigned WORD_BYTES    = CFG_DATA_W / BYTE_W;
  localparam int unsigned NUM_PAT_WORDS = 4;
  localparam int unsigned PAT_REG_BYTES = NUM_PAT_WORDS * WORD_BYTES;
  localparam int unsigned BYTE_SEL_W    = $clog2(WORD_BYTES);
  localparam int unsigned WORD_SEL_W    = $clog2(NUM_PAT_WORDS);

  localparam int unsigned SEEN_W        = $clog2(MAX_REGION + 1);
  localparam int unsigned WIN_LEN_W     = $clog2(MAX_PATTERN + 1);
  localparam logic [POS_W-1:0] POS_MAX  = {POS_W{1'b1}};

  localparam logic [BYTE_W-1:0] ASCII_LOWER_A = 8'h61;
  localparam logic [BYTE_W-1:0] ASCII_LOWER_Z = 8'h7A;
  localparam logic [BYTE_W-1:0] ASCII_CASE_OFFSET = 8'h20;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PAT_0_7      = 3'd0,
    REG_PAT_8_15     = 3'd1,
    REG_PAT_16_23    = 3'd2,
    REG_PAT_24_31    = 3'd3,
    REG_PAT_LEN      = 3'd4,
    REG_SEARCH_START = 3'd5
  } cfg_reg_e;

  // Pattern prepared for the window compare: entry j lines up with window entry j.
  typedef struct packed {
    logic [MAX_PATTERN-1:0][BYTE_W-1:0] pat_aligned;
    logic [MAX_PATTERN-1:0]             pat_mask;
    logic [WIN_LEN_W-1:0]               pat_len;
    logic [POS_W-1:0]                   start;
  } search_cfg_t;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] pos;
  } search_res_t;

  function automatic logic [BYTE_W-1:0] fold_case(input logic [BYTE_W-1:0] c);
    logic [BYTE_W-1:0] r;
    r = c;
    if (c >= ASCII_LOWER_A && c <= ASCII_LOWER_Z) begin
      r = c - ASCII_CASE_OFFSET;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/ciss_cfg_regs.sv
// Configuration registers and the aligned, case-folded pattern derived from them.
// Depends on ciss_pkg.
`default_nettype none

module ciss_cfg_regs import ciss_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  output search_cfg_t                cfg_o
);

  logic [NUM_PAT_WORDS-1:0][WORD_BYTES-1:0][BYTE_W-1:0] pat_q;
  logic [LEN_W-1:0]     len_q;
  logic [POS_W-1:0]     start_q;
  logic [WIN_LEN_W-1:0] len_clamped;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_q   <= '0;
      len_q   <= '0;
      start_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_PAT_0_7:      pat_q[0] <= cfg_data_i;
        REG_PAT_8_15:     pat_q[1] <= cfg_data_i;
        REG_PAT_16_23:    pat_q[2] <= cfg_data_i;
        REG_PAT_24_31:    pat_q[3] <= cfg_data_i;
        REG_PAT_LEN:      len_q    <= cfg_data_i[LEN_W-1:0];
        REG_SEARCH_START: start_q  <= cfg_data_i[POS_W-1:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // Cap the length at the window depth.
  assign len_clamped = ((LEN_W+1)'(len_q) > (LEN_W+1)'(MAX_PATTERN)) ?
                       WIN_LEN_W'(MAX_PATTERN) : WIN_LEN_W'(len_q);

  // Window entry j holds the byte matched against pattern byte len-1-j.
  always_comb begin
    logic [LEN_W-1:0] idx;
    cfg_o.pat_len = len_clamped;
    cfg_o.start   = start_q;
    for (int unsigned j = 0; j < MAX_PATTERN; j++) begin
      idx = LEN_W'(len_clamped) - LEN_W'(j) - LEN_W'(1);
      cfg_o.pat_mask[j] = WIN_LEN_W'(j) < len_clamped;
      if ((LEN_W+1)'(idx) >= (LEN_W+1)'(PAT_REG_BYTES)) begin
        cfg_o.pat_aligned[j] = '0;
      end else begin
        cfg_o.pat_aligned[j] = fold_case(
          pat_q[idx[BYTE_SEL_W+WORD_SEL_W-1:BYTE_SEL_W]][idx[BYTE_SEL_W-1:0]]);
      end
    end
  end

endmodule

`default_nettype wire

FILE: hdl/ciss_matcher.sv
// Byte window, region position and one-result-per-region control; compares
// the window against the aligned pattern in one pass. Depends on ciss_pkg.
`default_nettype none

module ciss_matcher import ciss_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              fire_i,
  input  wire logic [BYTE_W-1:0] data_i,
  input  wire logic              last_i,
  input  search_cfg_t            cfg_i,
  output logic                   emit_o,
  output search_res_t            res_o
);

  logic [MAX_PATTERN-1:0][BYTE_W-1:0] win_q, win_d;
  logic [SEEN_W-1:0] seen_q, seen_d;
  logic              given_q, given_d;

  logic [MAX_PATTERN-1:0] eq;
  logic              win_hit;
  logic [SEEN_W:0]   p_inc, len_ext, start_ext, s;
  logic              in_range, len_zero, hit_empty, hit_long, hit;

  // Window holds folded bytes, entry 0 newest.
  always_comb begin
    win_d[0] = fold_case(data_i);
    for (int unsigned j = 1; j < MAX_PATTERN; j++) begin
      win_d[j] = win_q[j-1];
    end
  end

  always_comb begin
    for (int unsigned j = 0; j < MAX_PATTERN; j++) begin
      eq[j] = !cfg_i.pat_mask[j] || (win_d[j] == cfg_i.pat_aligned[j]);
    end
  end
  assign win_hit = &eq;

  assign p_inc     = (SEEN_W+1)'(seen_q) + (SEEN_W+1)'(1);
  assign len_ext   = (SEEN_W+1)'(cfg_i.pat_len);
  assign start_ext = (SEEN_W+1)'(cfg_i.start);
  assign s         = p_inc - len_ext;
  assign in_range  = (SEEN_W+1)'(seen_q) < (SEEN_W+1)'(MAX_REGION);
  assign len_zero  = (cfg_i.pat_len == '0);

  assign hit_empty = ((SEEN_W+1)'(seen_q) >= start_ext) || (last_i && p_inc == start_ext);
  assign hit_long  = (p_inc >= len_ext) && (s >= start_ext) &&
                     (s <= (SEEN_W+1)'(POS_MAX)) && win_hit;
  assign hit       = !given_q && in_range && (len_zero ? hit_empty : hit_long);

  assign emit_o    = hit || (last_i && !given_q);
  assign res_o.found = hit;
  assign res_o.pos   = !hit ? '0 : (len_zero ? cfg_i.start : s[POS_W-1:0]);

  always_comb begin
    seen_d  = in_range ? SEEN_W'(p_inc) : seen_q;
    given_d = given_q || hit;
    // Start a new region after the last byte.
    if (last_i) begin
      seen_d  = '0;
      given_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q   <= '0;
      seen_q  <= '0;
      given_q <= 1'b0;
    end else if (fire_i) begin
      win_q   <= win_d;
      seen_q  <= seen_d;
      given_q <= given_d;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/case_insensitive_substring_search.sv
// Top level of the case-insensitive substring search: input register, matcher,
// result register and configuration port. Depends on ciss_pkg, ciss_cfg_regs,
// ciss_matcher and the assertion macro header.
//
//   channel  dir  handshake                  payload
//   s_axis   in   s_axis_tvalid/tready       tdata: data_byte; tlast: last_byte
//   m_axis   out  m_axis_tvalid/tready       tdata: match_position; tuser: found
//   cfg      in   cfg_valid/cfg_ready        cfg_index, cfg_data (always ready)
//
// One byte per cycle sustained while m_axis takes results; a result is presented after
// the byte that causes it is accepted: the byte waits in the input register, then the
// window compare loads the result register.
// The single window compare against all pattern bytes sets the one-byte-per-cycle figure.
// Reset clears control state, the window and the configuration registers at once; no clearing pass.
// While a result waits on m_axis, one more byte is held in the input register,
// then s_axis_tready drops.
`default_nettype none
`include "case_insensitive_substring_search_defines.svh"

module case_insensitive_substring_search import ciss_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  input  wire logic [BYTE_W-1:0]     s_axis_tdata_i,   // [7:0] data_byte
  input  wire logic                  s_axis_tlast_i,
  output logic                       m_axis_tvalid_o,
  input  wire logic                  m_axis_tready_i,
  output logic [POS_W-1:0]           m_axis_tdata_o,   // [15:0] match_position
  output logic [0:0]                 m_axis_tuser_o,   // [0] found
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  search_cfg_t       cfg;
  search_res_t       res, out_res_q;
  logic              emit, fire, in_xfer;
  logic              item_valid_q, item_last_q, out_valid_q;
  logic [BYTE_W-1:0] item_data_q;

  assign cfg_ready_o = 1'b1;

  ciss_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Advance the held byte when the result register is free or being drained.
  assign fire            = item_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !item_valid_q || fire;
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (in_xfer) begin
      item_valid_q <= 1'b1;
    end else if (fire) begin
      item_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      item_data_q <= s_axis_tdata_i;
      item_last_q <= s_axis_tlast_i;
    end
  end

  ciss_matcher u_matcher (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .data_i (item_data_q),
    .last_i (item_last_q),
    .cfg_i  (cfg),
    .emit_o (emit),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire && emit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && emit) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid_o   = out_valid_q;
  assign m_axis_tdata_o    = out_res_q.pos;
  assign m_axis_tuser_o[0] = out_res_q.found;

  // A not-found result only ever closes a region.
  `CISS_ASSERT_IMPLIES(a_miss_at_last, clk_i, rst_ni, fire && emit && !res.found, item_last_q)
  // A reported match never starts before the configured start.
  `CISS_ASSERT_IMPLIES(a_pos_after_start, clk_i, rst_ni, fire && res.found, res.pos >= cfg.start)
  // A loaded result reaches the output register in the next cycle.
  `CISS_ASSERT_NEXT(a_result_loaded, clk_i, rst_ni, fire && emit, m_axis_tvalid_o)

endmodule

`default_nettype wire
